// ===== rtl/core/ntc_sensor_average_fault_check_assert.svh =====
// assertion macros shared by the thermistor diagnostic checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef NTC_SENSOR_AVERAGE_FAULT_CHECK_ASSERT_SVH
`define NTC_SENSOR_AVERAGE_FAULT_CHECK_ASSERT_SVH

// same-cycle implication, quiet during reset
`define NTC_AFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define NTC_AFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ntc_afc_pkg.sv =====
// types, constants and codes for the thermistor averaging and fault check block
// no dependencies
package ntc_afc_pkg;

	// field widths
	localparam int IDX_W  = 3;
	localparam int ADC_W  = 12;
	localparam int TEMP_W = 9;
	localparam int BAND_W = 10;
	localparam int SUM_W  = 18;
	localparam int CNT_W  = 6;
	localparam int RES_W  = 26;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// default sizing
	localparam int SENSORS_DEF = 8;
	localparam int SPM_DEF     = 8;

	// divider arithmetic
	localparam logic [13:0]      PULLUP_OHMS = 14'd10000;
	localparam logic [ADC_W-1:0] ADC_FULL    = 12'd4095;

	// register reset values
	localparam logic [ADC_W-1:0]  SHORT_THR_RST = 12'd100;
	localparam logic [ADC_W-1:0]  OPEN_THR_RST  = 12'd4000;
	localparam logic [BAND_W-1:0] HYST_BAND_RST = 10'd20;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_SHORT_THR = 2'd0,
		REG_OPEN_THR  = 2'd1,
		REG_HYST_BAND = 2'd2
	} reg_idx_t;

	// live configuration
	typedef struct packed {
		logic [ADC_W-1:0]  short_threshold;
		logic [ADC_W-1:0]  open_threshold;
		logic [BAND_W-1:0] hysteresis_band;
	} cfg_t;

	// one entry of the per-sensor state memory
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             short_flag;
		logic             open_flag;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MEAN,
		ST_CLASS,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/ntc_afc_cfg.sv =====
// apb-style register file for thresholds and hysteresis band
// depends on ntc_afc_pkg
module ntc_afc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ntc_afc_pkg::PADDR_W-1:0] paddr,
	input  logic [ntc_afc_pkg::PDATA_W-1:0] pwdata,
	output logic [ntc_afc_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output ntc_afc_pkg::cfg_t             cfg
);
	import ntc_afc_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_threshold <= SHORT_THR_RST;
			cfg_q.open_threshold  <= OPEN_THR_RST;
			cfg_q.hysteresis_band <= HYST_BAND_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SHORT_THR: cfg_q.short_threshold <= pwdata[ADC_W-1:0];
				REG_OPEN_THR:  cfg_q.open_threshold  <= pwdata[ADC_W-1:0];
				REG_HYST_BAND: cfg_q.hysteresis_band <= pwdata[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SHORT_THR: prdata = PDATA_W'(cfg_q.short_threshold);
			REG_OPEN_THR:  prdata = PDATA_W'(cfg_q.open_threshold);
			REG_HYST_BAND: prdata = PDATA_W'(cfg_q.hysteresis_band);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/ntc_afc_mem.sv =====
// per-sensor state memory: running sum, count and sticky flags
// depends on ntc_afc_pkg; registered read, entry valid bits cleared by reset
module ntc_afc_mem #(
	parameter int DEPTH = ntc_afc_pkg::SENSORS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output ntc_afc_pkg::entry_t rd_entry,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  ntc_afc_pkg::entry_t wr_entry
);
	import ntc_afc_pkg::*;

	entry_t           mem [DEPTH];
	entry_t           rdata_s1;
	logic             hit_s1;
	logic [DEPTH-1:0] valid_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_entry;
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
	end

	// entry valid bits, a never-written entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				hit_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_entry = hit_s1 ? rdata_s1 : '0;

endmodule

// ===== rtl/core/ntc_afc_div.sv =====
// radix-2 restoring divider for the resistance quotient, one bit a cycle
// depends on ntc_afc_pkg
module ntc_afc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ntc_afc_pkg::RES_W-1:0] numerator,
	input  logic [ntc_afc_pkg::ADC_W-1:0] divisor,
	output logic                          busy,
	output logic [ntc_afc_pkg::RES_W-1:0] quotient
);
	import ntc_afc_pkg::*;

	localparam int STEP_W = $clog2(RES_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [RES_W-1:0]  quo_q;
	logic [ADC_W-1:0]  rem_q;
	logic [ADC_W-1:0]  den_q;
	logic [ADC_W:0]    trial;
	logic              fits;

	// trial subtract of the next partial remainder
	assign trial = {rem_q, quo_q[RES_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(RES_W - 1))
				busy_q <= 1'b0;
			step_q <= step_q + 1'b1;
		end
	end

	// numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numerator;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[RES_W-2:0], fits};
			rem_q <= fits ? ADC_W'(trial - {1'b0, den_q}) : trial[ADC_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/ntc_sensor_average_fault_check.sv =====
// A sample whose conversion failed or whose sensor index is out of range is accepted while
// idle and changes nothing. Any other sample goes through a read of the sensor's entry in
// the state memory, then the add and write-back. The sample that completes a block of
// SAMPLES_PER_MEAN then goes on through the mean, the zone classification and the 26-step
// radix-2 divider that forms the resistance; an invalid resistance skips the divider.
// One sample is in work at a time, while a finished result waits in the output register.
// No clearing pass after reset: per-entry valid bits make unwritten sensors read as zero.
// top level of the thermistor averaging and open/short diagnostic
// depends on ntc_afc_pkg, ntc_afc_cfg, ntc_afc_mem, ntc_afc_div
module ntc_sensor_average_fault_check #(
	parameter int SENSORS          = ntc_afc_pkg::SENSORS_DEF,
	parameter int SAMPLES_PER_MEAN = ntc_afc_pkg::SPM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ntc_afc_pkg::PADDR_W-1:0]     paddr,
	input  logic [ntc_afc_pkg::PDATA_W-1:0]     pwdata,
	output logic [ntc_afc_pkg::PDATA_W-1:0]     prdata,
	output logic                                pready,
	// sample channel
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [ntc_afc_pkg::IDX_W-1:0]       sensor_index,
	input  logic [ntc_afc_pkg::ADC_W-1:0]       adc_sample,
	input  logic                                sample_ok,
	input  logic signed [ntc_afc_pkg::TEMP_W-1:0] ecu_temp,
	input  logic                                ecu_temp_valid,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [ntc_afc_pkg::IDX_W-1:0]       result_sensor,
	output logic [ntc_afc_pkg::ADC_W-1:0]       mean_value,
	output logic                                short_fault,
	output logic                                open_fault,
	output logic [ntc_afc_pkg::RES_W-1:0]       resistance_ohms,
	output logic                                resistance_valid
);
	import ntc_afc_pkg::*;

	localparam int AW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	// reciprocal for an exact floor division of the sum by the block length
	localparam int DIV_L  = $clog2(SAMPLES_PER_MEAN);
	localparam int SHIFT  = SUM_W + DIV_L;
	localparam int RECIP  = ((1 << SHIFT) + SAMPLES_PER_MEAN - 1) / SAMPLES_PER_MEAN;
	localparam int RCP_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;

	cfg_t   cfg;
	state_t state_q, state_d;

	// control from the sequencer
	logic   take;
	logic   rd_en;
	logic   wr_en;
	entry_t wr_entry;
	entry_t rd_entry;
	logic   div_start;
	logic   div_busy;
	logic   out_load;

	// item held while in work
	logic [AW-1:0]    addr_q;
	logic [IDX_W-1:0] idx_q;
	logic [ADC_W-1:0] sample_q;
	logic             gate_q;
	logic [SUM_W-1:0] sum_q;
	logic             old_short_q;
	logic             old_open_q;
	logic [ADC_W-1:0] mean_q;
	logic             short_q;
	logic             open_q;
	logic             res_ok_q;

	// read-modify-write arithmetic
	logic [SUM_W-1:0]  sum_next;
	logic [CNT_W:0]    cnt_next;
	logic              block_done;
	logic [PROD_W-1:0] mean_prod;
	logic [ADC_W:0]    low_edge;
	logic [ADC_W:0]    mean_plus_band;
	logic              new_short;
	logic              new_open;
	logic              new_res_ok;
	logic [RES_W-1:0]  div_num;
	logic [ADC_W-1:0]  div_den;
	logic [RES_W-1:0]  quotient;
	logic              in_range;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_sensor_q;
	logic [ADC_W-1:0] out_mean_q;
	logic             out_short_q;
	logic             out_open_q;
	logic [RES_W-1:0] out_res_q;
	logic             out_res_ok_q;

	ntc_afc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ntc_afc_mem #(
		.DEPTH (SENSORS),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (AW'(sensor_index)),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (addr_q),
		.wr_entry (wr_entry)
	);

	ntc_afc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numerator (div_num),
		.divisor   (div_den),
		.busy      (div_busy),
		.quotient  (quotient)
	);

	// beat acceptance
	assign take     = sample_valid && !sample_stall;
	assign in_range = 32'(sensor_index) < SENSORS;
	assign rd_en    = take && sample_ok && in_range;

	// sum and count update of the entry just read
	assign sum_next   = rd_entry.sum + SUM_W'(sample_q);
	assign cnt_next   = {1'b0, rd_entry.count} + 1'b1;
	assign block_done = cnt_next == (CNT_W + 1)'(SAMPLES_PER_MEAN);

	// mean by reciprocal multiply
	assign mean_prod = PROD_W'(sum_q) * PROD_W'(RECIP);

	// zone classification and sticky flag update
	assign low_edge       = {1'b0, cfg.short_threshold} + (ADC_W + 1)'(cfg.hysteresis_band);
	assign mean_plus_band = {1'b0, mean_q} + (ADC_W + 1)'(cfg.hysteresis_band);
	always_comb begin
		new_short = 1'b0;
		new_open  = 1'b0;
		if (mean_q < cfg.short_threshold) begin
			new_short = gate_q | old_short_q;
		end else if ({1'b0, mean_q} < low_edge) begin
			new_short = old_short_q;
		end else if (mean_plus_band < {1'b0, cfg.open_threshold}) begin
			new_short = 1'b0;
		end else if (mean_q < cfg.open_threshold) begin
			new_open = old_open_q;
		end else begin
			new_open = gate_q | old_open_q;
		end
	end
	assign new_res_ok = !new_short && !new_open && (mean_q != ADC_FULL);

	// divider operands: pull-up times mean over the remaining span
	assign div_num = RES_W'(PULLUP_OHMS) * RES_W'(mean_q);
	assign div_den = ADC_FULL - mean_q;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and control
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		wr_en        = 1'b0;
		wr_entry     = '0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid && sample_ok && in_range)
					state_d = ST_READ;
			end
			ST_READ: begin
				wr_en = !block_done;
				wr_entry.sum        = sum_next;
				wr_entry.count      = cnt_next[CNT_W-1:0];
				wr_entry.short_flag = rd_entry.short_flag;
				wr_entry.open_flag  = rd_entry.open_flag;
				state_d = block_done ? ST_MEAN : ST_IDLE;
			end
			ST_MEAN: begin
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				wr_en = 1'b1;
				wr_entry.short_flag = new_short;
				wr_entry.open_flag  = new_open;
				div_start = new_res_ok;
				state_d   = new_res_ok ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (!div_busy)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// item registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_q   <= AW'(sensor_index);
			idx_q    <= sensor_index;
			sample_q <= adc_sample;
			gate_q   <= ecu_temp_valid && (ecu_temp > 9'sd0);
		end
		if (state_q == ST_READ) begin
			sum_q       <= sum_next;
			old_short_q <= rd_entry.short_flag;
			old_open_q  <= rd_entry.open_flag;
		end
		if (state_q == ST_MEAN)
			mean_q <= mean_prod[SHIFT +: ADC_W];
		if (state_q == ST_CLASS) begin
			short_q  <= new_short;
			open_q   <= new_open;
			res_ok_q <= new_res_ok;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sensor_q <= idx_q;
			out_mean_q   <= mean_q;
			out_short_q  <= short_q;
			out_open_q   <= open_q;
			out_res_q    <= res_ok_q ? quotient : '0;
			out_res_ok_q <= res_ok_q;
		end
	end

	assign result_valid     = out_valid_q;
	assign result_sensor    = out_sensor_q;
	assign mean_value       = out_mean_q;
	assign short_fault      = out_short_q;
	assign open_fault       = out_open_q;
	assign resistance_ohms  = out_res_q;
	assign resistance_valid = out_res_ok_q;

endmodule

// ===== rtl/core/ntc_afc_checker.sv =====
// port-level checks for the thermistor diagnostic, bound to the top level
// depends on ntc_afc_pkg and the assertion macro header
`include "ntc_sensor_average_fault_check_assert.svh"

module ntc_afc_checker #(
	parameter int SENSORS = ntc_afc_pkg::SENSORS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  sample_valid,
	input logic                                  sample_stall,
	input logic [ntc_afc_pkg::IDX_W-1:0]         sensor_index,
	input logic                                  sample_ok,
	input logic                                  result_valid,
	input logic                                  result_stall,
	input logic [ntc_afc_pkg::ADC_W-1:0]         mean_value,
	input logic                                  short_fault,
	input logic                                  open_fault,
	input logic [ntc_afc_pkg::RES_W-1:0]         resistance_ohms,
	input logic                                  resistance_valid
);
	import ntc_afc_pkg::*;

	// a stalled result beat stays offered
	`NTC_AFC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid,
		"result beat dropped while stalled")

	// a sample that touches state occupies the block for the next cycle
	`NTC_AFC_ASSERT_NEXT(a_busy_after_sample,
		sample_valid && !sample_stall && sample_ok && (32'(sensor_index) < SENSORS),
		sample_stall, "sample accepted during state update")

	// the two sticky flags exclude each other
	`NTC_AFC_ASSERT_NOW(a_flags_exclusive, result_valid, !(short_fault && open_fault),
		"short and open flags both set")

	// a valid resistance needs clean flags and a mean below full scale
	`NTC_AFC_ASSERT_NOW(a_res_valid_cond, result_valid && resistance_valid,
		!short_fault && !open_fault && (mean_value != ADC_FULL),
		"resistance marked valid on a fault or full-scale mean")

	// an invalid resistance reads as zero
	`NTC_AFC_ASSERT_NOW(a_res_zero, result_valid && !resistance_valid,
		resistance_ohms == '0, "invalid resistance not zero")

endmodule

bind ntc_sensor_average_fault_check ntc_afc_checker #(.SENSORS(SENSORS)) u_checker (.*);

// ===== dv/tb_ntc_sensor_average_fault_check.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the thermistor averaging and open/short diagnostic block
// depends on ntc_afc_pkg and ntc_sensor_average_fault_check; reads no files
module tb_ntc_sensor_average_fault_check;
	import ntc_afc_pkg::*;

	localparam int SENSOR_COUNT = SENSORS_DEF;
	localparam int BLOCK_LEN    = SPM_DEF;
	// guard sized for the slowest legal run, roughly 2000 beats with gaps and stalls
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int MAX_PRINTED  = 100;

	// one sample beat as driven on the input channel
	typedef struct {
		logic [IDX_W-1:0]         sensor;
		logic [ADC_W-1:0]         sample;
		logic                     ok;
		logic signed [TEMP_W-1:0] temp;
		logic                     temp_valid;
	} sample_beat_t;

	// one diagnostic result beat
	typedef struct {
		logic [IDX_W-1:0] sensor;
		logic [ADC_W-1:0] mean;
		logic             short_f;
		logic             open_f;
		logic [RES_W-1:0] ohms;
		logic             ohms_valid;
	} diag_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [PADDR_W-1:0]       paddr;
	logic [PDATA_W-1:0]       pwdata;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	logic                     sample_valid;
	logic                     sample_stall;
	logic [IDX_W-1:0]         sensor_index;
	logic [ADC_W-1:0]         adc_sample;
	logic                     sample_ok;
	logic signed [TEMP_W-1:0] ecu_temp;
	logic                     ecu_temp_valid;
	logic                     result_valid;
	logic                     result_stall;
	logic [IDX_W-1:0]         result_sensor;
	logic [ADC_W-1:0]         mean_value;
	logic                     short_fault;
	logic                     open_fault;
	logic [RES_W-1:0]         resistance_ohms;
	logic                     resistance_valid;

	// predictor copy of the per-sensor state and the live registers
	logic [SUM_W-1:0] acc_sum    [SENSOR_COUNT];
	logic [CNT_W-1:0] acc_cnt    [SENSOR_COUNT];
	logic             short_hold [SENSOR_COUNT];
	logic             open_hold  [SENSOR_COUNT];
	cfg_t             live_cfg;

	diag_result_t pending_diag [$];
	diag_result_t want_diag;
	int           target_mean [SENSOR_COUNT];
	int           err_count;
	int           cycle_count;
	int           send_idle_pct;
	int           stall_pct;

	ntc_sensor_average_fault_check dut (.*);

	always #6 clk = ~clk;

	// mismatch reporting, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// accumulation for one accepted beat, with zone classification and resistance when it ends a block
	function automatic void predict_diag(input sample_beat_t b);
		int unsigned  s;
		int unsigned  mean;
		bit           gate;
		diag_result_t r;
		if (!b.ok)
			return;
		s = b.sensor;
		if (s >= SENSOR_COUNT)
			return;
		gate = b.temp_valid && (b.temp > 0);
		acc_sum[s] = acc_sum[s] + b.sample;
		acc_cnt[s] = acc_cnt[s] + 1'b1;
		if (acc_cnt[s] != 0 && acc_cnt[s] < BLOCK_LEN)
			return;
		mean = (int'(acc_sum[s]) / BLOCK_LEN) & 'hFFF;
		acc_sum[s] = '0;
		acc_cnt[s] = '0;
		// zones tested in order, first match wins, sums in full precision
		if (mean < int'(live_cfg.short_threshold)) begin
			if (gate)
				short_hold[s] = 1'b1;
			open_hold[s] = 1'b0;
		end else if (mean < int'(live_cfg.short_threshold) + int'(live_cfg.hysteresis_band)) begin
			open_hold[s] = 1'b0;
		end else if (mean + int'(live_cfg.hysteresis_band) < int'(live_cfg.open_threshold)) begin
			short_hold[s] = 1'b0;
			open_hold[s]  = 1'b0;
		end else if (mean < int'(live_cfg.open_threshold)) begin
			short_hold[s] = 1'b0;
		end else begin
			if (gate)
				open_hold[s] = 1'b1;
			short_hold[s] = 1'b0;
		end
		r.sensor     = IDX_W'(s);
		r.mean       = ADC_W'(mean);
		r.short_f    = short_hold[s];
		r.open_f     = open_hold[s];
		r.ohms       = '0;
		r.ohms_valid = 1'b0;
		if (!short_hold[s] && !open_hold[s] && mean < 4095) begin
			r.ohms       = RES_W'((10000 * mean) / (4095 - mean));
			r.ohms_valid = 1'b1;
		end
		pending_diag.push_back(r);
	endfunction

	// drive one sample beat, with a random gap first, and wait for acceptance
	task automatic send_sample(input sample_beat_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		sample_valid   <= 1'b1;
		sensor_index   <= b.sensor;
		adc_sample     <= b.sample;
		sample_ok      <= b.ok;
		ecu_temp       <= b.temp;
		ecu_temp_valid <= b.temp_valid;
		do
			@(posedge clk);
		while (sample_stall);
		predict_diag(b);
	endtask

	task automatic send_fields(input int s, input int v, input bit ok, input int t, input bit tv);
		sample_beat_t b;
		b.sensor     = IDX_W'(s);
		b.sample     = ADC_W'(v);
		b.ok         = ok;
		b.temp       = TEMP_W'(t);
		b.temp_valid = tv;
		send_sample(b);
	endtask

	// stop sending, let all results come out and the sequencer go quiet
	task automatic settle_block();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_diag.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write then read-back over the configuration port
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] want;
		want = '0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_SHORT_THR: live_cfg.short_threshold = value[ADC_W-1:0];
			REG_OPEN_THR:  live_cfg.open_threshold  = value[ADC_W-1:0];
			REG_HYST_BAND: live_cfg.hysteresis_band = value[BAND_W-1:0];
			default: ;
		endcase
		case (idx)
			REG_SHORT_THR: want = PDATA_W'(live_cfg.short_threshold);
			REG_OPEN_THR:  want = PDATA_W'(live_cfg.open_threshold);
			REG_HYST_BAND: want = PDATA_W'(live_cfg.hysteresis_band);
			default: ;
		endcase
		// read phase of the same register
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx != REG_UNMAPPED && prdata !== want)
			report_mismatch("prdata", prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input int short_thr, input int open_thr, input int band);
		write_reg(REG_SHORT_THR, PDATA_W'(short_thr));
		write_reg(REG_OPEN_THR, PDATA_W'(open_thr));
		write_reg(REG_HYST_BAND, PDATA_W'(band));
		// unmapped index must leave everything alone
		write_reg(REG_UNMAPPED, $urandom);
	endtask

	function automatic int clamp_adc(input int v);
		if (v < 0)
			return 0;
		if (v > 4095)
			return 4095;
		return v;
	endfunction

	// block target aimed at zone edges, at the scale ends or at random, so the hold bands get exercised
	function automatic int pick_target();
		int base;
		case ($urandom_range(7))
			0: base = int'(live_cfg.short_threshold);
			1: base = int'(live_cfg.short_threshold) + int'(live_cfg.hysteresis_band);
			2: base = int'(live_cfg.open_threshold) - int'(live_cfg.hysteresis_band);
			3: base = int'(live_cfg.open_threshold);
			4: base = 0;
			5: base = 4095;
			default: base = $urandom_range(4095);
		endcase
		return clamp_adc(base + int'($urandom_range(6)) - 3);
	endfunction

	// interleaved blocks around per-sensor targets, plus failed conversions and stray samples
	task automatic run_random(input int n_good, input int noise_pct);
		sample_beat_t b;
		int           sent;
		int           s;
		sent = 0;
		while (sent < n_good) begin
			s            = $urandom_range(SENSOR_COUNT - 1);
			b.sensor     = IDX_W'(s);
			b.temp       = TEMP_W'($urandom);
			b.temp_valid = ($urandom_range(99) < 80);
			if ($urandom_range(99) < noise_pct) begin
				b.ok     = 1'b0;
				b.sample = ADC_W'($urandom);
			end else begin
				b.ok = 1'b1;
				if (acc_cnt[s] == 0)
					target_mean[s] = pick_target();
				b.sample = ADC_W'(clamp_adc(target_mean[s] + int'($urandom_range(4)) - 2));
				if ($urandom_range(99) < 5)
					b.sample = ADC_W'($urandom);
			end
			sent++;
			send_sample(b);
		end
	endtask

	// edge values at reset defaults: full-scale, zero, temperature extremes, failed conversion
	task automatic test_directed_edges();
		int i;
		send_fields(7, 4095, 1'b0, 255, 1'b1);
		for (i = 0; i < BLOCK_LEN; i++)
			send_fields(0, 0, 1'b1, 1, 1'b1);
		for (i = 0; i < BLOCK_LEN; i++)
			send_fields(7, 4095, 1'b1, 255, 1'b1);
		// gate closed: negative, zero and invalid temperatures
		for (i = 0; i < BLOCK_LEN - 1; i++)
			send_fields(3, (i % 2) ? 4095 : 0, 1'b1, -128, i % 3 == 0);
		send_fields(3, 4095, 1'b1, 0, 1'b1);
		settle_block();
	endtask

	// every register through its extremes, overlapping zones and an oversized band
	task automatic test_register_settings();
		apply_cfg(0, 4095, 0);
		run_random(80, 10);
		settle_block();
		apply_cfg(4095, 0, 1023);
		run_random(80, 10);
		settle_block();
		apply_cfg(200, 500, 1023);
		run_random(80, 10);
		settle_block();
		apply_cfg(2000, 2100, 60);
		run_random(80, 10);
		settle_block();
		apply_cfg(SHORT_THR_RST, OPEN_THR_RST, HYST_BAND_RST);
		run_random(80, 10);
		settle_block();
	endtask

	// long random runs under each idling pattern, fresh registers per phase
	task automatic test_idle_phases();
		int p;
		int idle_tab  [4] = '{0, 86, 0, 22};
		int stall_tab [4] = '{0, 0, 86, 22};
		for (p = 0; p < 4; p++) begin
			apply_cfg($urandom_range(600), 4095 - $urandom_range(600), $urandom_range(1023));
			send_idle_pct = idle_tab[p];
			stall_pct     = stall_tab[p];
			run_random(380, 10);
			settle_block();
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// receiver back-pressure
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// run-length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result checker: each accepted beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_diag.size() == 0) begin
				report_mismatch("unexpected result, sensor", result_sensor, -1);
			end else begin
				want_diag = pending_diag.pop_front();
				if (result_sensor !== want_diag.sensor)
					report_mismatch("result_sensor", result_sensor, want_diag.sensor);
				if (mean_value !== want_diag.mean)
					report_mismatch("mean_value", mean_value, want_diag.mean);
				if (short_fault !== want_diag.short_f)
					report_mismatch("short_fault", short_fault, want_diag.short_f);
				if (open_fault !== want_diag.open_f)
					report_mismatch("open_fault", open_fault, want_diag.open_f);
				if (resistance_ohms !== want_diag.ohms)
					report_mismatch("resistance_ohms", resistance_ohms, want_diag.ohms);
				if (resistance_valid !== want_diag.ohms_valid)
					report_mismatch("resistance_valid", resistance_valid, want_diag.ohms_valid);
			end
		end
	end

	initial begin
		int i;
		clk            = 1'b0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		sample_valid   = 1'b0;
		sensor_index   = '0;
		adc_sample     = '0;
		sample_ok      = 1'b0;
		ecu_temp       = '0;
		ecu_temp_valid = 1'b0;
		result_stall   = 1'b0;
		err_count      = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		live_cfg.short_threshold = SHORT_THR_RST;
		live_cfg.open_threshold  = OPEN_THR_RST;
		live_cfg.hysteresis_band = HYST_BAND_RST;
		for (i = 0; i < SENSOR_COUNT; i++) begin
			acc_sum[i]     = '0;
			acc_cnt[i]     = '0;
			short_hold[i]  = 1'b0;
			open_hold[i]   = 1'b0;
			target_mean[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_register_settings();
		test_idle_phases();

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== ntc_sensor_average_fault_check.f =====
+incdir+rtl/core
rtl/core/ntc_afc_pkg.sv
rtl/core/ntc_afc_cfg.sv
rtl/core/ntc_afc_mem.sv
rtl/core/ntc_afc_div.sv
rtl/core/ntc_sensor_average_fault_check.sv
rtl/core/ntc_afc_checker.sv
dv/tb_ntc_sensor_average_fault_check.sv
